[rtl/core/ole_pkg.sv]
`timescale 1ns / 1ps
package ole_pkg;
    typedef enum logic [3:0] {
        REQ_APPEND     = 4'd0,
        REQ_PREPEND    = 4'd1,
        REQ_INS_BEFORE = 4'd2,
        REQ_INS_AFTER  = 4'd3,
        REQ_DEL_FIRST  = 4'd4,
        REQ_DEL_LAST   = 4'd5,
        REQ_DEL_AFTER  = 4'd6,
        REQ_CLEAR      = 4'd7,
        REQ_LIST       = 4'd8
    } t_req;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NO_NEXT   = 3'd3,
        ST_FULL      = 3'd4,
        ST_ELEMENT   = 3'd5
    } t_status;

    localparam int MAX_RESULTS = 32;

    typedef struct packed {
        logic [3:0]  req_type;
        logic signed [31:0] target_value;
        logic signed [31:0] new_value;
    } t_req_item;

    typedef struct packed {
        logic [2:0]  status;
        logic signed [31:0] element_value;
        logic [5:0]  element_count;
        logic        last;
    } t_rsp_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_EXEC,
        S_OUT,
        S_LIST
    } t_state;
endpackage

[rtl/core/ole_if.sv]
`timescale 1ns / 1ps
interface ole_req_if;
    logic                  valid;
    logic                  ready;
    ole_pkg::t_req_item    payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ole_rsp_if;
    logic                  valid;
    logic                  ready;
    ole_pkg::t_rsp_item    payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/ordered_list_engine_top.sv]
`timescale 1ns / 1ps
// Singly linked list engine over a pool of CAPACITY nodes. One request at a time, and a new
// request is taken only once the previous response has been accepted. A request that searches
// for a target or needs the tail (append, delete last, insert and delete by target) walks the
// list one node per cycle through registered reads of the value and link memories. A walk
// visits at most node_count+1 nodes. Prepend, delete first, clear and unused codes visit one
// node. A list request then gives one result per element, one per cycle while the sink takes
// them, at most 32, the last flagged. Status reports empty, target missing, no successor or
// full; new nodes take the lowest free slot.
module ordered_list_engine_top #(
    parameter int CAPACITY = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ole_req_if.sink   i_req,
    ole_rsp_if.source o_rsp
);
    import ole_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] r_val [CAPACITY];
    logic [AW-1:0]      r_link [CAPACITY];
    logic [CAPACITY-1:0] r_used, n_used;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;

    t_state r_state, n_state;
    t_req_item r_in, n_in;
    logic [AW-1:0] r_cur, n_cur;      // node being looked at
    logic [AW-1:0] r_prev, n_prev;    // node before r_cur
    logic [CW-1:0] r_pos, n_pos;      // position of r_cur (of r_prev after a delete-after match)
    logic          r_found, n_found;
    t_rsp_item r_rsp, n_rsp;
    logic      r_ovalid, n_ovalid;
    logic [5:0] r_emit, n_emit;

    // value and link of r_cur
    logic signed [31:0] r_cur_val;
    logic [AW-1:0]      r_cur_link;

    // one memory write port
    logic          w_en;
    logic [AW-1:0] w_addr;
    logic          w_val_en;
    logic signed [31:0] w_val;
    logic [AW-1:0] w_link;
    // second write of a link on append, insert and delete after: done as separate port on link array
    logic          w2_en;
    logic [AW-1:0] w2_addr, w2_link;

    logic [CW-1:0] free_idx;
    logic          full;
    logic [CW-1:0] lim;
    logic [AW-1:0] nxt;

    always_comb begin
        free_idx = CW'(CAPACITY);
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) free_idx = CW'(i);
        end
    end
    assign full = (r_count >= CW'(CAPACITY)) || (free_idx >= CW'(CAPACITY));
    assign nxt  = r_cur_link;

    assign i_req.ready   = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_rsp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_val_en) r_val[w_addr] <= w_val;
            r_link[w_addr] <= w_link;
        end
        if (w2_en) r_link[w2_addr] <= w2_link;
        r_cur_val  <= r_val[n_cur];
        r_cur_link <= r_link[n_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_head   <= n_head;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_in    <= n_in;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_rsp   <= n_rsp;
        r_emit  <= n_emit;
    end

    always_comb begin
        n_state = r_state; n_used = r_used; n_head = r_head; n_count = r_count;
        n_in = r_in; n_cur = r_cur; n_prev = r_prev; n_pos = r_pos; n_found = r_found;
        n_rsp = r_rsp; n_ovalid = r_ovalid; n_emit = r_emit;
        w_en = 1'b0; w_addr = '0; w_val_en = 1'b0; w_val = '0; w_link = '0;
        w2_en = 1'b0; w2_addr = '0; w2_link = '0;
        lim = (int'(r_count) > MAX_RESULTS) ? CW'(MAX_RESULTS) : r_count;
        if (r_ovalid && o_rsp.ready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_in = i_req.payload;
                    n_cur = r_head; n_prev = r_head; n_pos = '0; n_found = 1'b0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // walk until target found, or to the tail (append, delete last) or past it (searches)
                case (r_in.req_type)
                    REQ_INS_BEFORE, REQ_INS_AFTER, REQ_DEL_AFTER: begin
                        if (r_pos >= r_count) begin
                            n_state = S_EXEC;
                        end else if (r_cur_val == r_in.target_value) begin
                            n_found = 1'b1; n_state = S_EXEC;
                            // delete after: step onto the victim so its link is read
                            if (r_in.req_type == REQ_DEL_AFTER) begin
                                n_prev = r_cur; n_cur = nxt;
                            end
                        end else begin
                            n_prev = r_cur; n_cur = nxt; n_pos = r_pos + 1'b1;
                        end
                    end
                    REQ_APPEND, REQ_DEL_LAST: begin
                        if (r_pos + 1'b1 >= r_count) n_state = S_EXEC;
                        else begin
                            n_prev = r_cur; n_cur = nxt; n_pos = r_pos + 1'b1;
                        end
                    end
                    default: n_state = S_EXEC;
                endcase
            end
            S_EXEC: begin
                n_rsp.status = ST_DONE;
                n_rsp.element_value = '0;
                n_rsp.last = 1'b1;
                n_state = S_OUT;
                case (r_in.req_type)
                    REQ_APPEND, REQ_PREPEND: begin
                        if (full) n_rsp.status = ST_FULL;
                        else begin
                            w_en = 1'b1; w_val_en = 1'b1; w_addr = AW'(free_idx);
                            w_val = r_in.new_value;
                            n_used[AW'(free_idx)] = 1'b1;
                            if (r_in.req_type == REQ_PREPEND) begin
                                w_link = r_head; n_head = AW'(free_idx);
                            end else if (r_count == '0) begin
                                n_head = AW'(free_idx);
                            end else begin
                                w2_en = 1'b1; w2_addr = r_cur; w2_link = AW'(free_idx);
                            end
                            n_count = r_count + 1'b1;
                        end
                    end
                    REQ_INS_BEFORE, REQ_INS_AFTER: begin
                        if (r_in.req_type == REQ_INS_BEFORE && r_count == '0)
                            n_rsp.status = ST_EMPTY;
                        else if (!r_found) n_rsp.status = ST_NOT_FOUND;
                        else if (full) n_rsp.status = ST_FULL;
                        else begin
                            w_en = 1'b1; w_val_en = 1'b1; w_addr = AW'(free_idx);
                            w_val = r_in.new_value;
                            n_used[AW'(free_idx)] = 1'b1;
                            n_count = r_count + 1'b1;
                            if (r_in.req_type == REQ_INS_AFTER) begin
                                w_link = nxt;
                                w2_en = 1'b1; w2_addr = r_cur; w2_link = AW'(free_idx);
                            end else if (r_pos == '0) begin
                                w_link = r_head; n_head = AW'(free_idx);
                            end else begin
                                w_link = r_cur;
                                w2_en = 1'b1; w2_addr = r_prev; w2_link = AW'(free_idx);
                            end
                        end
                    end
                    REQ_DEL_FIRST: begin
                        if (r_count == '0) n_rsp.status = ST_EMPTY;
                        else begin
                            n_used[r_head] = 1'b0;
                            n_count = r_count - 1'b1;
                            n_head = (r_count == CW'(1)) ? '0 : nxt;
                        end
                    end
                    REQ_DEL_LAST: begin
                        if (r_count == '0) n_rsp.status = ST_EMPTY;
                        else begin
                            n_used[r_cur] = 1'b0;
                            n_count = r_count - 1'b1;
                            if (r_count == CW'(1)) n_head = '0;
                        end
                    end
                    REQ_DEL_AFTER: begin
                        // r_prev is the target and r_cur the node after it
                        if (!r_found) n_rsp.status = ST_NOT_FOUND;
                        else if (r_pos + 1'b1 >= r_count) n_rsp.status = ST_NO_NEXT;
                        else begin
                            w2_en = 1'b1; w2_addr = r_prev; w2_link = nxt;
                            n_used[r_cur] = 1'b0;
                            n_count = r_count - 1'b1;
                        end
                    end
                    REQ_CLEAR: begin
                        n_used = '0; n_head = '0; n_count = '0;
                    end
                    REQ_LIST: begin
                        if (r_count == '0) n_rsp.status = ST_EMPTY;
                        else begin
                            n_state = S_LIST; n_cur = r_head; n_emit = '0;
                        end
                    end
                    default: ;
                endcase
                n_rsp.element_count = 6'(n_count);
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_rsp.status = ST_ELEMENT;
                    n_rsp.element_value = r_cur_val;
                    n_rsp.element_count = 6'(r_count);
                    n_rsp.last = (7'(r_emit) + 7'd1 == 7'(lim));
                    n_cur = nxt;
                    n_emit = r_emit + 1'b1;
                    if (n_rsp.last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
